// File: design/ffra_pkg.sv
package ffra_pkg;

  // datapath width for addresses, sizes and growth amounts (room for carries past 2^32)
  localparam int WW = 36;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef enum logic [1:0] {
    TOK_HOLD,
    TOK_LOAD,
    TOK_FWD,
    TOK_BACK
  } tok_op_e;

  typedef struct packed {
    logic [31:0] size;
    logic        rsv;
  } region_entry_t;

  typedef struct packed {
    cell_op_e      op;
    tok_op_e       tok;
    region_entry_t wdata;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    STAT_ALLOC     = 3'd0,
    STAT_FREED     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NO_GROW   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_NULL      = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GDIV,
    ST_S_WAIT,
    ST_S_AL,
    ST_S_FIT,
    ST_P_SUB,
    ST_L_CHK,
    ST_L_WR,
    ST_S_END,
    ST_G_AL,
    ST_G_KDIV,
    ST_G_AV,
    ST_G_ADIV,
    ST_G_CMP,
    ST_G_WR,
    ST_F_WAIT,
    ST_F_CMP,
    ST_F_NX,
    ST_F_NXW,
    ST_F_NXR,
    ST_F_NXM,
    ST_F_PV,
    ST_F_PVW,
    ST_F_PVR,
    ST_F_RM,
    ST_DONE
  } state_e;

endpackage

// File: design/ffra_cell.sv
module ffra_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    first_i,
  input  ffra_pkg::chain_cmd_t    cmd_i,
  input  ffra_pkg::region_entry_t left_i,
  input  ffra_pkg::region_entry_t right_i,
  input  logic                    tok_left_i,
  input  logic                    tok_right_i,
  output ffra_pkg::region_entry_t region_o,
  output logic                    tok_o,
  output ffra_pkg::region_entry_t rd_o
);

  ffra_pkg::region_entry_t region_q, region_d;
  logic tok_q, tok_d;
  logic past_q, past_d;

  always_comb begin
    region_d = region_q;
    case (cmd_i.op)
      ffra_pkg::OP_WRITE: begin
        if (tok_q) region_d = cmd_i.wdata;
      end
      ffra_pkg::OP_INSERT: begin
        if (tok_q) region_d = cmd_i.wdata;
        else if (past_q) region_d = left_i;
      end
      ffra_pkg::OP_REMOVE: begin
        if (tok_q || past_q) region_d = right_i;
      end
      default: region_d = region_q;
    endcase
  end

  // token marks the working entry, past marks entries behind it
  always_comb begin
    tok_d  = tok_q;
    past_d = past_q;
    case (cmd_i.tok)
      ffra_pkg::TOK_LOAD: begin
        tok_d  = first_i;
        past_d = ~first_i;
      end
      ffra_pkg::TOK_FWD: begin
        tok_d  = tok_left_i;
        past_d = past_q & ~tok_left_i;
      end
      ffra_pkg::TOK_BACK: begin
        tok_d  = tok_right_i;
        past_d = past_q | tok_q;
      end
      default: begin
        tok_d  = tok_q;
        past_d = past_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      past_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      past_q <= past_d;
    end
  end

  assign region_o = region_q;
  assign tok_o    = tok_q;
  assign rd_o     = tok_q ? region_q : '0;

endmodule

// File: design/ffra_chain.sv
module ffra_chain #(
  parameter int N = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ffra_pkg::chain_cmd_t    cmd_i,
  output ffra_pkg::region_entry_t rd_o
);

  ffra_pkg::region_entry_t reg_v [N];
  ffra_pkg::region_entry_t rd_v  [N];
  logic [N-1:0]            tok_v;
  ffra_pkg::region_entry_t rd_or;
  ffra_pkg::region_entry_t rd_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    ffra_pkg::region_entry_t left_w, right_w;
    logic tl_w, tr_w;
    if (k == 0) begin : g_lo
      assign left_w = '0;
      assign tl_w   = 1'b0;
    end else begin : g_lm
      assign left_w = reg_v[k-1];
      assign tl_w   = tok_v[k-1];
    end
    if (k == N - 1) begin : g_hi
      assign right_w = '0;
      assign tr_w    = 1'b0;
    end else begin : g_hm
      assign right_w = reg_v[k+1];
      assign tr_w    = tok_v[k+1];
    end
    ffra_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .first_i     (k == 0),
      .cmd_i       (cmd_i),
      .left_i      (left_w),
      .right_i     (right_w),
      .tok_left_i  (tl_w),
      .tok_right_i (tr_w),
      .region_o    (reg_v[k]),
      .tok_o       (tok_v[k]),
      .rd_o        (rd_v[k])
    );
  end

  // only the token cell drives a nonzero value
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < N; k++) begin
      rd_or = rd_or | rd_v[k];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_or;
  end

  assign rd_o = rd_q;

  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_v))
    else $error("more than one token in the region chain");

endmodule

// File: design/ffra_div.sv
module ffra_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ffra_pkg::WW-1:0] num_i,
  input  logic [ffra_pkg::WW-1:0] den_i,
  output logic                    done_o,
  output logic [ffra_pkg::WW-1:0] rem_o
);

  localparam int CNTW = $clog2(ffra_pkg::WW + 1);

  logic [ffra_pkg::WW-1:0] num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic [ffra_pkg::WW:0]   trial;

  // restoring division, one quotient bit per cycle, remainder only
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[ffra_pkg::WW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNTW'(ffra_pkg::WW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) rem_d = ffra_pkg::WW'(trial - {1'b0, den_q});
      else rem_d = trial[ffra_pkg::WW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: design/first_fit_region_allocator_unit.sv
// first-fit heap region allocator with coalescing
// requests arrive on the s_ channel: tuser is the request kind (0 allocate, 1 free),
// tdata carries req_size, align_log2 and free_addr. one result beat per request
// leaves on the m_ channel: tuser is the status code, tdata the allocated address.
// regions live in a chain of cells; a token marks the entry being worked on and
// splits and merges shift the chain by one entry in a single register update
// one request is in flight at a time; s_tready_o is high only while idle
// a free walks the table with a wait and a compare state per entry, then merges the
// freed entry with free neighbours; an allocate walks it with a wait, an align and a
// fit state per entry per pass, after a state that rounds the growth step up to whole
// pages; growing a free last region takes up to two serial divisions; a request that
// grows the heap walks the table once more after each growth
// a finished result sits in the output register; the next request is taken while
// it waits, but that request cannot finish until the receiver takes the beat
// reset empties the table and the heap and loads the register defaults;
// region contents are not cleared, only the entry count
// config writes take effect at once and are meant only while no request is in flight
module first_fit_region_allocator_unit #(
  parameter int MAX_REGIONS = 64,
  parameter int PAGE_BYTES  = 4096   // power of two
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port: 0 heap_base, 1 min_growth, 2 heap_limit, 3 region_limit
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [71:0] s_tdata_i,   // req_size[31:0], align_log2[36:32], free_addr[68:37]
  input  logic        s_tuser_i,   // req_type
  // result channel
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // result_addr
  output logic [2:0]  m_tuser_o    // status
);

  localparam int WW   = ffra_pkg::WW;
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int XW   = (CW > 7) ? CW : 7;
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_MING = 2'd1;
  localparam logic [1:0] REG_HLIM = 2'd2;
  localparam logic [1:0] REG_RLIM = 2'd3;
  localparam logic [WW-1:0] SPAN = WW'(64'h1_0000_0000);
  localparam logic [WW-1:0] PAGE = WW'(PAGE_BYTES);

  // config registers
  logic [31:0] base_q, hlim_q;
  logic [24:0] ming_q;
  logic [6:0]  rlim_q;

  // control and working registers
  ffra_pkg::state_e  state_q, state_d;
  ffra_pkg::status_e stat_q, stat_d;
  logic [CW-1:0]     cnt_q, cnt_d, i_q, i_d;
  logic [31:0]       heap_q, heap_d;
  logic [31:0]       sz_q, sz_d, amask_q, amask_d, faddr_q, faddr_d, res_q, res_d;
  logic [31:0]       cur_size_q, cur_size_d, last_size_q, last_size_d;
  logic              cur_rsv_q, cur_rsv_d, last_rsv_q, last_rsv_d, fail_q, fail_d;
  logic [WW-1:0]     addr_q, addr_d, last_addr_q, last_addr_d, al_q, al_d, pad_q, pad_d;
  logic [WW-1:0]     gx_q, gx_d, g_q, g_d, d_q, d_d, kg_q, kg_d, avg_q, avg_d;
  logic [WW-1:0]     grow_q, grow_d;
  logic              m_valid_q, m_valid_d;
  logic [31:0]       m_addr_q, m_addr_d;
  logic [2:0]        m_stat_q, m_stat_d;

  ffra_pkg::chain_cmd_t    cmd;
  ffra_pkg::region_entry_t rd;
  logic                    div_start, div_done;
  logic [WW-1:0]           div_num, div_den, div_rem;

  // request fields
  logic [31:0] in_size, in_faddr;
  logic [4:0]  in_alog;
  logic [32:0] in_sz33;
  logic [WW-1:0] in_gx;
  logic        in_acc;

  assign in_size  = s_tdata_i[31:0];
  assign in_alog  = s_tdata_i[36:32];
  assign in_faddr = s_tdata_i[68:37];
  assign in_sz33  = ({1'b0, in_size} + 33'd3) & ~33'd3;
  assign in_gx    = (WW'(in_sz33) + (WW'(in_sz33) << 1)) >> 1;
  assign in_acc   = s_tvalid_i && s_tready_o;

  // shared datapath terms
  logic [WW-1:0] amask_w, sz_w, al_c, pad_c, cap_c, heap_w, avn_c, al_l_c, need_c, g_raw, mg_w;
  logic [XW-1:0] lim_c;
  logic          full_c, hit_c, app_fail_c, need_gt_c, last_taken_c, found_c, kg_big_c;

  assign amask_w      = WW'(amask_q);
  assign sz_w         = WW'(sz_q);
  assign heap_w       = WW'(heap_q);
  assign al_c         = (addr_q + amask_w) & ~amask_w;
  assign pad_c        = al_c - addr_q;
  assign hit_c        = !cur_rsv_q && (WW'(cur_size_q) >= sz_w + pad_q)
                        && (al_q + sz_w <= SPAN);
  assign cap_c        = (WW'(hlim_q) < SPAN - WW'(base_q)) ? WW'(hlim_q) : SPAN - WW'(base_q);
  assign avn_c        = cap_c - heap_w;
  assign app_fail_c   = (heap_w > cap_c) || (g_q > avn_c);
  assign al_l_c       = (last_addr_q + amask_w) & ~amask_w;
  assign need_c       = sz_w + al_l_c - last_addr_q;
  assign need_gt_c    = need_c > WW'(last_size_q);
  assign last_taken_c = (cnt_q == '0) || last_rsv_q;
  assign found_c      = addr_q == WW'(faddr_q);
  assign kg_big_c     = kg_q > avg_q;
  // 1.5 times the size rounded up to whole pages
  assign g_raw        = (gx_q + PAGE - WW'(1)) & ~(PAGE - WW'(1));
  assign mg_w         = (WW'(ming_q) < PAGE) ? PAGE : WW'(ming_q);

  // region limit clamped to 1..MAX_REGIONS
  assign lim_c  = (rlim_q == '0) ? XW'(1) :
                  ((XW'(rlim_q) > XW'(MAX_REGIONS)) ? XW'(MAX_REGIONS) : XW'(rlim_q));
  assign full_c = XW'(cnt_q) >= lim_c;

  ffra_chain #(.N(MAX_REGIONS)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rd_o   (rd)
  );

  ffra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffra_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser_i) state_d = (in_faddr == '0) ? ffra_pkg::ST_DONE : ffra_pkg::ST_F_WAIT;
          else state_d = in_sz33[32] ? ffra_pkg::ST_DONE : ffra_pkg::ST_GDIV;
        end
      end
      ffra_pkg::ST_GDIV:   state_d = ffra_pkg::ST_S_WAIT;
      ffra_pkg::ST_S_WAIT: state_d = ffra_pkg::ST_S_AL;
      ffra_pkg::ST_S_AL:   state_d = (i_q == cnt_q) ? ffra_pkg::ST_S_END : ffra_pkg::ST_S_FIT;
      ffra_pkg::ST_S_FIT: begin
        if (!hit_c) state_d = ffra_pkg::ST_S_WAIT;
        else if (pad_q != '0) state_d = full_c ? ffra_pkg::ST_DONE : ffra_pkg::ST_P_SUB;
        else state_d = ffra_pkg::ST_L_CHK;
      end
      ffra_pkg::ST_P_SUB:  state_d = ffra_pkg::ST_L_CHK;
      ffra_pkg::ST_L_CHK: begin
        if (cur_size_q > sz_q && !full_c) state_d = ffra_pkg::ST_L_WR;
        else state_d = ffra_pkg::ST_DONE;
      end
      ffra_pkg::ST_L_WR:   state_d = ffra_pkg::ST_DONE;
      ffra_pkg::ST_S_END: begin
        if (!last_taken_c) state_d = ffra_pkg::ST_G_AL;
        else if (full_c || app_fail_c) state_d = ffra_pkg::ST_DONE;
        else state_d = ffra_pkg::ST_S_WAIT;
      end
      ffra_pkg::ST_G_AL:   state_d = need_gt_c ? ffra_pkg::ST_G_KDIV : ffra_pkg::ST_G_AV;
      ffra_pkg::ST_G_KDIV: if (div_done) state_d = ffra_pkg::ST_G_AV;
      ffra_pkg::ST_G_AV:   state_d = (heap_w > cap_c) ? ffra_pkg::ST_G_CMP : ffra_pkg::ST_G_ADIV;
      ffra_pkg::ST_G_ADIV: if (div_done) state_d = ffra_pkg::ST_G_CMP;
      ffra_pkg::ST_G_CMP:  state_d = ffra_pkg::ST_G_WR;
      ffra_pkg::ST_G_WR:   state_d = fail_q ? ffra_pkg::ST_DONE : ffra_pkg::ST_S_WAIT;
      ffra_pkg::ST_F_WAIT: state_d = ffra_pkg::ST_F_CMP;
      ffra_pkg::ST_F_CMP: begin
        if (i_q == cnt_q) state_d = ffra_pkg::ST_DONE;
        else if (found_c) state_d = ffra_pkg::ST_F_NX;
        else state_d = ffra_pkg::ST_F_WAIT;
      end
      ffra_pkg::ST_F_NX:   state_d = (i_q + 1'b1 < cnt_q) ? ffra_pkg::ST_F_NXW : ffra_pkg::ST_F_PV;
      ffra_pkg::ST_F_NXW:  state_d = ffra_pkg::ST_F_NXR;
      ffra_pkg::ST_F_NXR:  state_d = rd.rsv ? ffra_pkg::ST_F_PV : ffra_pkg::ST_F_NXM;
      ffra_pkg::ST_F_NXM:  state_d = ffra_pkg::ST_F_PV;
      ffra_pkg::ST_F_PV:   state_d = (i_q != '0) ? ffra_pkg::ST_F_PVW : ffra_pkg::ST_DONE;
      ffra_pkg::ST_F_PVW:  state_d = ffra_pkg::ST_F_PVR;
      ffra_pkg::ST_F_PVR:  state_d = rd.rsv ? ffra_pkg::ST_DONE : ffra_pkg::ST_F_RM;
      ffra_pkg::ST_F_RM:   state_d = ffra_pkg::ST_DONE;
      ffra_pkg::ST_DONE:   if (!m_valid_q || m_tready_i) state_d = ffra_pkg::ST_IDLE;
      default:             state_d = ffra_pkg::ST_IDLE;
    endcase
  end

  // datapath and chain commands
  always_comb begin
    stat_d      = stat_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    heap_d      = heap_q;
    sz_d        = sz_q;
    amask_d     = amask_q;
    faddr_d     = faddr_q;
    res_d       = res_q;
    cur_size_d  = cur_size_q;
    cur_rsv_d   = cur_rsv_q;
    last_size_d = last_size_q;
    last_rsv_d  = last_rsv_q;
    last_addr_d = last_addr_q;
    fail_d      = fail_q;
    addr_d      = addr_q;
    al_d        = al_q;
    pad_d       = pad_q;
    gx_d        = gx_q;
    g_d         = g_q;
    d_d         = d_q;
    kg_d        = kg_q;
    avg_d       = avg_q;
    grow_d      = grow_q;
    m_valid_d   = m_valid_q & ~m_tready_i;
    m_addr_d    = m_addr_q;
    m_stat_d    = m_stat_q;
    cmd         = '{op: ffra_pkg::OP_NOP, tok: ffra_pkg::TOK_HOLD, wdata: '0};
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    case (state_q)
      ffra_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          amask_d = (32'd1 << in_alog) - 32'd1;
          faddr_d = in_faddr;
          sz_d    = in_sz33[31:0];
          gx_d    = in_gx;
          if (s_tuser_i) begin
            if (in_faddr == '0) stat_d = ffra_pkg::STAT_NULL;
            else begin
              stat_d  = ffra_pkg::STAT_NOT_FOUND;
              cmd.tok = ffra_pkg::TOK_LOAD;
              i_d     = '0;
              addr_d  = WW'(base_q);
            end
          end else if (in_sz33[32]) begin
            stat_d = ffra_pkg::STAT_NO_GROW;
          end
        end
      end
      ffra_pkg::ST_GDIV: begin
        g_d     = (g_raw < mg_w) ? mg_w : g_raw;
        cmd.tok = ffra_pkg::TOK_LOAD;
        i_d     = '0;
        addr_d  = WW'(base_q);
      end
      ffra_pkg::ST_S_AL: begin
        al_d       = al_c;
        pad_d      = pad_c;
        cur_size_d = rd.size;
        cur_rsv_d  = rd.rsv;
      end
      ffra_pkg::ST_S_FIT: begin
        if (hit_c) begin
          res_d = al_q[31:0];
          if (pad_q != '0) begin
            if (full_c) stat_d = ffra_pkg::STAT_FULL;
            else begin
              // free pre-alignment part goes in front of the region
              cmd.op    = ffra_pkg::OP_INSERT;
              cmd.tok   = ffra_pkg::TOK_FWD;
              cmd.wdata = '{size: pad_q[31:0], rsv: 1'b0};
              cnt_d     = cnt_q + 1'b1;
            end
          end
        end else begin
          last_addr_d = addr_q;
          last_size_d = cur_size_q;
          last_rsv_d  = cur_rsv_q;
          addr_d      = addr_q + WW'(cur_size_q);
          i_d         = i_q + 1'b1;
          // the token stays on the last cell when the table is completely used
          if (i_q != CW'(MAX_REGIONS - 1)) cmd.tok = ffra_pkg::TOK_FWD;
        end
      end
      ffra_pkg::ST_P_SUB: begin
        cmd.op     = ffra_pkg::OP_WRITE;
        cmd.wdata  = '{size: cur_size_q - pad_q[31:0], rsv: 1'b0};
        cur_size_d = cur_size_q - pad_q[31:0];
      end
      ffra_pkg::ST_L_CHK: begin
        if (cur_size_q > sz_q) begin
          if (full_c) stat_d = ffra_pkg::STAT_FULL;
          else begin
            // reserved part in front, free leftover written next
            cmd.op    = ffra_pkg::OP_INSERT;
            cmd.tok   = ffra_pkg::TOK_FWD;
            cmd.wdata = '{size: sz_q, rsv: 1'b1};
            cnt_d     = cnt_q + 1'b1;
          end
        end else begin
          cmd.op    = ffra_pkg::OP_WRITE;
          cmd.wdata = '{size: cur_size_q, rsv: 1'b1};
          stat_d    = ffra_pkg::STAT_ALLOC;
        end
      end
      ffra_pkg::ST_L_WR: begin
        cmd.op    = ffra_pkg::OP_WRITE;
        cmd.wdata = '{size: cur_size_q - sz_q, rsv: 1'b0};
        stat_d    = ffra_pkg::STAT_ALLOC;
      end
      ffra_pkg::ST_S_END: begin
        if (last_taken_c) begin
          if (full_c) stat_d = ffra_pkg::STAT_FULL;
          else if (app_fail_c) stat_d = ffra_pkg::STAT_NO_GROW;
          else begin
            // token sits just past the last entry: append a free region there
            cmd.op    = ffra_pkg::OP_WRITE;
            cmd.tok   = ffra_pkg::TOK_LOAD;
            cmd.wdata = '{size: g_q[31:0], rsv: 1'b0};
            cnt_d     = cnt_q + 1'b1;
            heap_d    = heap_q + g_q[31:0];
            i_d       = '0;
            addr_d    = WW'(base_q);
          end
        end
      end
      ffra_pkg::ST_G_AL: begin
        if (need_gt_c) begin
          d_d       = need_c - WW'(last_size_q);
          div_start = 1'b1;
          div_num   = need_c - WW'(last_size_q);
          div_den   = g_q;
        end else begin
          kg_d = g_q;
        end
      end
      ffra_pkg::ST_G_KDIV: begin
        if (div_done) kg_d = (div_rem == '0) ? d_q : d_q - div_rem + g_q;
      end
      ffra_pkg::ST_G_AV: begin
        if (heap_w > cap_c) avg_d = '0;
        else begin
          div_start = 1'b1;
          div_num   = avn_c;
          div_den   = g_q;
        end
      end
      ffra_pkg::ST_G_ADIV: begin
        if (div_done) avg_d = avn_c - div_rem;
      end
      ffra_pkg::ST_G_CMP: begin
        // with a full table the token already sits on the last entry
        if (cnt_q != CW'(MAX_REGIONS)) cmd.tok = ffra_pkg::TOK_BACK;
        fail_d  = kg_big_c;
        grow_d  = kg_big_c ? avg_q : kg_q;
      end
      ffra_pkg::ST_G_WR: begin
        // the free last region absorbs the growth
        cmd.op    = ffra_pkg::OP_WRITE;
        cmd.wdata = '{size: last_size_q + grow_q[31:0], rsv: 1'b0};
        heap_d    = heap_q + grow_q[31:0];
        if (fail_q) stat_d = ffra_pkg::STAT_NO_GROW;
        else begin
          cmd.tok = ffra_pkg::TOK_LOAD;
          i_d     = '0;
          addr_d  = WW'(base_q);
        end
      end
      ffra_pkg::ST_F_CMP: begin
        if (i_q != cnt_q) begin
          if (found_c) begin
            cmd.op     = ffra_pkg::OP_WRITE;
            cmd.wdata  = '{size: rd.size, rsv: 1'b0};
            cur_size_d = rd.size;
            stat_d     = ffra_pkg::STAT_FREED;
          end else begin
            addr_d  = addr_q + WW'(rd.size);
            i_d     = i_q + 1'b1;
            cmd.tok = ffra_pkg::TOK_FWD;
          end
        end
      end
      ffra_pkg::ST_F_NX: begin
        if (i_q + 1'b1 < cnt_q) cmd.tok = ffra_pkg::TOK_FWD;
      end
      ffra_pkg::ST_F_NXR: begin
        cmd.tok = ffra_pkg::TOK_BACK;
        if (!rd.rsv) begin
          // fold the free successor into this entry
          cmd.op     = ffra_pkg::OP_REMOVE;
          cnt_d      = cnt_q - 1'b1;
          cur_size_d = cur_size_q + rd.size;
        end
      end
      ffra_pkg::ST_F_NXM: begin
        cmd.op    = ffra_pkg::OP_WRITE;
        cmd.wdata = '{size: cur_size_q, rsv: 1'b0};
      end
      ffra_pkg::ST_F_PV: begin
        if (i_q != '0) cmd.tok = ffra_pkg::TOK_BACK;
      end
      ffra_pkg::ST_F_PVR: begin
        if (!rd.rsv) begin
          // free predecessor absorbs this entry
          cmd.op    = ffra_pkg::OP_WRITE;
          cmd.tok   = ffra_pkg::TOK_FWD;
          cmd.wdata = '{size: rd.size + cur_size_q, rsv: 1'b0};
        end
      end
      ffra_pkg::ST_F_RM: begin
        cmd.op = ffra_pkg::OP_REMOVE;
        cnt_d  = cnt_q - 1'b1;
      end
      ffra_pkg::ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_stat_d  = stat_q;
          m_addr_d  = (stat_q == ffra_pkg::STAT_ALLOC) ? res_q : '0;
        end
      end
      default: begin
        cmd.op = ffra_pkg::OP_NOP;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      ming_q <= 25'h0040000;
      hlim_q <= 32'h1000_0000;
      rlim_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE: base_q <= cfg_data_i;
        REG_MING: ming_q <= cfg_data_i[24:0];
        REG_HLIM: hlim_q <= cfg_data_i;
        REG_RLIM: rlim_q <= cfg_data_i[6:0];
        default:  base_q <= base_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffra_pkg::ST_IDLE;
      cnt_q     <= '0;
      heap_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      heap_q    <= heap_d;
      m_valid_q <= m_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    stat_q      <= stat_d;
    i_q         <= i_d;
    sz_q        <= sz_d;
    amask_q     <= amask_d;
    faddr_q     <= faddr_d;
    res_q       <= res_d;
    cur_size_q  <= cur_size_d;
    cur_rsv_q   <= cur_rsv_d;
    last_size_q <= last_size_d;
    last_rsv_q  <= last_rsv_d;
    last_addr_q <= last_addr_d;
    fail_q      <= fail_d;
    addr_q      <= addr_d;
    al_q        <= al_d;
    pad_q       <= pad_d;
    gx_q        <= gx_d;
    g_q         <= g_d;
    d_q         <= d_d;
    kg_q        <= kg_d;
    avg_q       <= avg_d;
    grow_q      <= grow_d;
    m_addr_q    <= m_addr_d;
    m_stat_q    <= m_stat_d;
  end

  assign s_tready_o = state_q == ffra_pkg::ST_IDLE;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_addr_q;
  assign m_tuser_o  = m_stat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(cnt_q) <= XW'(MAX_REGIONS))
    else $error("region count past table depth");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ffra_pkg::ST_G_KDIV || state_q == ffra_pkg::ST_G_ADIV))
    else $error("divider finished with no state waiting on it");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(state_q == ffra_pkg::ST_DONE))
    else $error("result beat raised outside of completion");

endmodule
